@@ rtl/qpps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qpps_pkg - shared types and constants of the quadrature position servo
// Item and result structs, state and gain bundles, op and register codes,
// fixed-point limits and the saturating error helper.
// ----------------------------------------------------------------------------
package qpps_pkg;

  // field widths
  localparam int CNT_W  = 32;
  localparam int GAIN_W = 32;
  localparam int ACC_W  = 64;
  localparam int DUTY_W = 7;
  localparam int CFG_IDX_W = 2;

  // fixed-point format of gains and drive accumulator
  localparam int FRAC_BITS  = 16;
  localparam int DUTY_RANGE = 100;

  // accumulator thresholds for one duty step and for full duty
  localparam logic signed [ACC_W-1:0] DUTY_ONE = ACC_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [ACC_W-1:0] DUTY_SAT =
    ACC_W'(64'(DUTY_RANGE + 1) <<< FRAC_BITS);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(DUTY_RANGE);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] ERR_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] ERR_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // item op codes
  localparam logic [1:0] OP_EDGE_A  = 2'd0;
  localparam logic [1:0] OP_EDGE_B  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_SET_REF = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LAST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BEFORE = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic                    level_a;
    logic                    level_b;
    logic signed [CNT_W-1:0] target_counts;
  } qpps_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       forward_duty;
    logic [DUTY_W-1:0]       reverse_duty;
    logic signed [CNT_W-1:0] count_now;
    logic signed [CNT_W-1:0] error_now;
  } qpps_out_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic signed [CNT_W-1:0] reference;
    logic signed [CNT_W-1:0] error_prev;
    logic signed [CNT_W-1:0] error_prev2;
    logic signed [ACC_W-1:0] drive_acc;
  } qpps_state_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_now;
    logic signed [GAIN_W-1:0] gain_last;
    logic signed [GAIN_W-1:0] gain_before;
  } qpps_gains_t;

  // reference minus count, saturated to the signed count range
  function automatic logic signed [CNT_W-1:0] sat_error(
    input logic signed [CNT_W-1:0] reference,
    input logic signed [CNT_W-1:0] count
  );
    logic [CNT_W:0] diff;
    diff = {reference[CNT_W-1], reference} - {count[CNT_W-1], count};
    if (diff[CNT_W] != diff[CNT_W-1]) begin
      sat_error = diff[CNT_W] ? ERR_MIN : ERR_MAX;
    end else begin
      sat_error = diff[CNT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/qpps_servo_path.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qpps_servo_path - single-pass datapath of the position servo
// From the registered item and the current state, forms the next state and
// the result: encoder count step, reference load, or the velocity-form PID
// update with accumulator saturation and duty clamping.
// ----------------------------------------------------------------------------
module qpps_servo_path import qpps_pkg::*; (
  input  wire qpps_in_t    item,
  input  wire qpps_state_t st,
  input  wire qpps_gains_t gains,
  output qpps_state_t      st_nxt,
  output qpps_out_t        res
);

  logic                    step_up;
  logic signed [CNT_W-1:0] count_step;
  logic signed [CNT_W-1:0] err_cur;
  logic signed [ACC_W-1:0] prod_now;
  logic signed [ACC_W-1:0] prod_last;
  logic signed [ACC_W-1:0] prod_before;
  logic [ACC_W+1:0]        acc_sum;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [ACC_W-1:0] acc_neg;
  logic signed [ACC_W-1:0] acc_shr;
  logic [ACC_W-1:0]        neg_shr;
  logic [DUTY_W-1:0]       fwd_duty;
  logic [DUTY_W-1:0]       rev_duty;

  // quadrature direction: edge on a counts up when levels differ,
  // edge on b counts up when they match
  assign step_up    = (item.op == OP_EDGE_A) ? (item.level_a ^ item.level_b)
                                             : ~(item.level_a ^ item.level_b);
  assign count_step = step_up ? (st.count + CNT_W'(1)) : (st.count - CNT_W'(1));

  // current error for the pid update
  assign err_cur = sat_error(st.reference, st.count);

  // three parallel signed products
  assign prod_now    = ACC_W'(gains.gain_now)    * ACC_W'(err_cur);
  assign prod_last   = ACC_W'(gains.gain_last)   * ACC_W'(st.error_prev);
  assign prod_before = ACC_W'(gains.gain_before) * ACC_W'(st.error_prev2);

  // exact sum with two guard bits, then saturate to the accumulator range
  assign acc_sum = {{2{st.drive_acc[ACC_W-1]}}, st.drive_acc}
                 + {{2{prod_now[ACC_W-1]}}, prod_now}
                 + {{2{prod_last[ACC_W-1]}}, prod_last}
                 + {{2{prod_before[ACC_W-1]}}, prod_before};

  always_comb begin
    if (acc_sum[ACC_W+1:ACC_W-1] == 3'b000 || acc_sum[ACC_W+1:ACC_W-1] == 3'b111) begin
      acc_new = acc_sum[ACC_W-1:0];
    end else begin
      acc_new = acc_sum[ACC_W+1] ? ACC_MIN : ACC_MAX;
    end
  end

  // integer part truncated toward zero, one path per sign
  assign acc_shr = acc_new >>> FRAC_BITS;
  assign acc_neg = -acc_new;
  assign neg_shr = acc_neg >> FRAC_BITS;

  // duty clamp by error sign
  always_comb begin
    fwd_duty = '0;
    rev_duty = '0;
    if (err_cur > 0) begin
      if (acc_new >= DUTY_SAT) begin
        fwd_duty = DUTY_FULL;
      end else if (acc_new >= DUTY_ONE) begin
        fwd_duty = acc_shr[DUTY_W-1:0];
      end
    end else begin
      if (acc_new <= -DUTY_SAT) begin
        rev_duty = DUTY_FULL;
      end else if (acc_new <= -DUTY_ONE) begin
        rev_duty = neg_shr[DUTY_W-1:0];
      end
    end
  end

  // next state and result by op
  always_comb begin
    st_nxt           = st;
    res.forward_duty = '0;
    res.reverse_duty = '0;
    unique case (item.op)
      OP_EDGE_A, OP_EDGE_B: begin
        st_nxt.count = count_step;
      end
      OP_SET_REF: begin
        st_nxt.reference = item.target_counts;
      end
      OP_TICK: begin
        st_nxt.drive_acc   = acc_new;
        st_nxt.error_prev  = err_cur;
        st_nxt.error_prev2 = st.error_prev;
        res.forward_duty   = fwd_duty;
        res.reverse_duty   = rev_duty;
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.count_now = st_nxt.count;
    res.error_now = sat_error(st_nxt.reference, st_nxt.count);
  end

endmodule
`default_nettype wire

@@ rtl/quadrature_position_pid_servo_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_position_pid_servo_unit - encoder-driven position servo
// Quadrature count, reference register and velocity-form PID with duty
// output, one result per item.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : valid/ready items: encoder edge on a or b, control tick, or a
//           new reference in counts. One transfer per cycle is sustained while out_ready holds.
//   out_* : valid/ready results, exactly one per item, in item order:
//           forward and reverse duty (non-zero only on a tick), count and
//           saturated error after the item.
//   cfg_* : write port for the three q16.16 gains; write only while idle.
// An item passes through an input register, then the single-pass datapath
// (three 32x32 multipliers and a 66-bit sum) into the output register.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single pass, which updates the state in the same cycle.
// When the receiver stalls, the result holds, one more item waits in the
// input register, and in_ready then drops until the output is taken.
// Reset clears count, reference, error history, accumulator, gains and
// both valid flags.
// ----------------------------------------------------------------------------
module quadrature_position_pid_servo_unit import qpps_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire qpps_in_t            in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output qpps_out_t                out_data,
  input  wire                      cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0]     cfg_index,
  input  wire  [GAIN_W-1:0]        cfg_wdata
);

  logic        in_vld_r;
  qpps_in_t    in_item_r;
  logic        out_vld_r;
  qpps_out_t   out_item_r;
  qpps_state_t st_r;
  qpps_state_t st_nxt;
  qpps_gains_t gains_r;
  qpps_out_t   res;
  logic        go;

  // stage advances when an item is held and the output slot frees up
  assign go       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || go;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // datapath
  qpps_servo_path u_path (
    .item   (in_item_r),
    .st     (st_r),
    .gains  (gains_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_item_r <= res;
    end
  end

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_NOW:    gains_r.gain_now    <= cfg_wdata;
        CFG_GAIN_LAST:   gains_r.gain_last   <= cfg_wdata;
        CFG_GAIN_BEFORE: gains_r.gain_before <= cfg_wdata;
        default:         gains_r             <= gains_r;
      endcase
    end
  end

  // checks
  a_duty_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.forward_duty == '0 || out_item_r.reverse_duty == '0))
    else $error("forward and reverse duty both active");

  a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.forward_duty != '0) |-> (out_item_r.error_now > 0))
    else $error("forward duty with non-positive error");

  a_rev_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.reverse_duty != '0) |-> (out_item_r.error_now <= 0))
    else $error("reverse duty with positive error");

  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_vld_r)
    else $error("processed item gave no result");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (in_item_r.op == OP_TICK || in_item_r.op == OP_SET_REF)) |=> $stable(st_r.count))
    else $error("count moved on a non-edge item");

endmodule
`default_nettype wire

@@ tb/quadrature_position_pid_servo_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_position_pid_servo_unit_test - servo unit testbench
// Drives encoder edges, control ticks and reference loads through the
// valid/ready item port and programs the three gains between phases. A
// shadow copy of the count, error history and drive accumulator predicts
// every result, and each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module quadrature_position_pid_servo_unit_test;
  import qpps_pkg::*;

  localparam int SETTLE      = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;

  localparam logic [GAIN_W-1:0] GAIN_MAX  = 32'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_MIN  = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] GAIN_HALF = 32'h0000_8000;
  localparam logic [GAIN_W-1:0] GAIN_UNIT = 32'h0000_0001;

  // shadow of the servo state, expected results in item order
  class servo_shadow;
    logic signed [GAIN_W-1:0] g_now, g_last, g_before;
    logic signed [CNT_W-1:0]  count, reference, err_prev, err_prev2;
    logic signed [ACC_W-1:0]  drive_acc;
    qpps_out_t                awaited[$];
    int                       errors;

    function new();
      g_now = '0; g_last = '0; g_before = '0;
      count = '0; reference = '0; err_prev = '0; err_prev2 = '0;
      drive_acc = '0;
      errors = 0;
    endfunction

    function void write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        CFG_GAIN_NOW:    g_now = val;
        CFG_GAIN_LAST:   g_last = val;
        CFG_GAIN_BEFORE: g_before = val;
        default: ;
      endcase
    endfunction

    // reference minus count, clipped to the count range
    function logic signed [CNT_W-1:0] position_error();
      longint diff;
      diff = longint'(reference) - longint'(count);
      if (diff > longint'(ERR_MAX)) return ERR_MAX;
      if (diff < longint'(ERR_MIN)) return ERR_MIN;
      return diff[CNT_W-1:0];
    endfunction

    function void apply_item(qpps_in_t it);
      qpps_out_t                res;
      logic signed [CNT_W-1:0]  err;
      logic signed [ACC_W+1:0]  total;
      longint                   whole;
      res = '0;
      case (it.op)
        OP_EDGE_A:  count = (it.level_a != it.level_b) ? count + 1 : count - 1;
        OP_EDGE_B:  count = (it.level_a == it.level_b) ? count + 1 : count - 1;
        OP_SET_REF: reference = it.target_counts;
        default: begin
          // velocity-form update, summed exactly then clipped to 64 bits
          err = position_error();
          total = (ACC_W+2)'(drive_acc);
          total = total + longint'(g_now) * longint'(err);
          total = total + longint'(g_last) * longint'(err_prev);
          total = total + longint'(g_before) * longint'(err_prev2);
          if (total > ACC_MAX) drive_acc = ACC_MAX;
          else if (total < ACC_MIN) drive_acc = ACC_MIN;
          else drive_acc = total[ACC_W-1:0];
          err_prev2 = err_prev;
          err_prev = err;
          // integer part, truncated toward zero
          whole = longint'(drive_acc) / (longint'(1) <<< FRAC_BITS);
          if (err > 0) begin
            if (whole > DUTY_RANGE) res.forward_duty = DUTY_W'(DUTY_RANGE);
            else if (whole > 0) res.forward_duty = DUTY_W'(whole);
          end else begin
            if (whole < -DUTY_RANGE) res.reverse_duty = DUTY_W'(DUTY_RANGE);
            else if (whole < 0) res.reverse_duty = DUTY_W'(-whole);
          end
        end
      endcase
      res.count_now = count;
      res.error_now = position_error();
      awaited.push_back(res);
    endfunction

    function void check_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(qpps_out_t got);
      qpps_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, got %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      check_field("forward_duty", 64'(want.forward_duty), 64'(got.forward_duty));
      check_field("reverse_duty", 64'(want.reverse_duty), 64'(got.reverse_duty));
      check_field("count_now", 64'(want.count_now), 64'(got.count_now));
      check_field("error_now", 64'(want.error_now), 64'(got.error_now));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  qpps_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  qpps_out_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GAIN_NOW;
  logic [GAIN_W-1:0]    cfg_wdata = '0;

  servo_shadow sb;
  bit          quiet = 1'b0;
  bit          enc_a = 1'b0;
  bit          enc_b = 1'b0;
  bit          moving_up = 1'b1;
  int          idle_cycles = 0;

  quadrature_position_pid_servo_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 9);
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic qpps_in_t make_item(logic [1:0] op, logic a, logic b,
                                         logic [CNT_W-1:0] target);
    qpps_in_t it;
    it.op = op;
    it.level_a = a;
    it.level_b = b;
    it.target_counts = target;
    return it;
  endfunction

  function automatic qpps_in_t random_item();
    qpps_in_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.level_a = 1'($urandom);
    it.level_b = 1'($urandom);
    it.target_counts = $urandom;
    if (pick < 50) begin
      if ($urandom_range(0, 19) == 0) moving_up = !moving_up;
      if (pick < 43) begin
        // clean gray step in the current direction of travel
        if ((enc_a == enc_b) == moving_up) begin
          it.op = OP_EDGE_A;
          enc_a = !enc_a;
        end else begin
          it.op = OP_EDGE_B;
          enc_b = !enc_b;
        end
        it.level_a = enc_a;
        it.level_b = enc_b;
      end else begin
        // glitch edge with arbitrary levels
        it.op = $urandom_range(0, 1) ? OP_EDGE_A : OP_EDGE_B;
      end
    end else if (pick < 85) begin
      it.op = OP_TICK;
    end else begin
      it.op = OP_SET_REF;
      if (pick < 97) it.target_counts = sb.count + $urandom_range(0, 600) - 300;
    end
    return it;
  endfunction

  // one item transfer, with random gaps before it
  task automatic send_item(input qpps_in_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_item(it);
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_gain(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] g0, g1, g2);
    write_reg(CFG_GAIN_NOW, g0);
    write_reg(CFG_GAIN_LAST, g1);
    write_reg(CFG_GAIN_BEFORE, g2);
  endtask

  // pid-shaped gains: kp+ki+kd, -(kp+2kd), kd
  task automatic pid_gains();
    int kp, ki, kd;
    kp = $urandom_range(0, 32'h0002_0000);
    ki = $urandom_range(0, 32'h0000_2000);
    kd = $urandom_range(0, 32'h0001_0000);
    write_gains(kp + ki + kd, -(kp + 2 * kd), kd);
  endtask

  function automatic logic [GAIN_W-1:0] extreme_gain();
    case ($urandom_range(0, 3))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // steer the accumulator back to zero: coarse pass then unit gain
  task automatic recentre_drive();
    logic signed [GAIN_W-1:0] gain;
    longint                   want;
    for (int pass = 0; pass < 2; pass++) begin
      gain = (pass == 0) ? GAIN_MAX : GAIN_UNIT;
      wait_drained(SETTLE);
      write_gains(gain, '0, '0);
      repeat (6) begin
        want = -(sb.drive_acc / gain);
        if (want > (64'sd1 <<< 30)) want = 64'sd1 <<< 30;
        if (want < -(64'sd1 <<< 30)) want = -(64'sd1 <<< 30);
        send_item(make_item(OP_SET_REF, 1'b0, 1'b0, CNT_W'(sb.count + want)));
        send_item(make_item(OP_TICK, 1'b0, 1'b0, '0));
      end
    end
  endtask

  task automatic run_phase(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      // sender holds off once until every result is back
      if (i == n_items / 2) wait_drained(0);
      send_item(random_item());
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // every edge/level combination on both channels, count dips below zero
    write_gains(GAIN_HALF, '0, '0);
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        send_item(make_item(OP_EDGE_A, a[0], b[0], '0));
      end
    end
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        send_item(make_item(OP_EDGE_B, a[0], b[0], '1));
      end
    end
    repeat (3) send_item(make_item(OP_EDGE_A, 1'b0, 1'b0, '0));

    // fractional drive, truncation toward zero on both signs
    send_item(make_item(OP_TICK, 1'b0, 1'b0, '0));
    send_item(make_item(OP_SET_REF, 1'b0, 1'b0, -32'sd10));
    send_item(make_item(OP_TICK, 1'b1, 1'b1, '1));
    send_item(make_item(OP_TICK, 1'b0, 1'b1, '0));

    // error clipped high, accumulator driven to both rails
    send_item(make_item(OP_SET_REF, 1'b1, 1'b0, ERR_MAX));
    wait_drained(SETTLE);
    write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
    repeat (2) send_item(make_item(OP_TICK, 1'b0, 1'b0, '0));
    wait_drained(SETTLE);
    write_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN);
    repeat (2) send_item(make_item(OP_TICK, 1'b0, 1'b0, '0));

    // error clipped low with a positive count
    repeat (4) send_item(make_item(OP_EDGE_A, 1'b1, 1'b0, '0));
    send_item(make_item(OP_SET_REF, 1'b0, 1'b0, ERR_MIN));
    send_item(make_item(OP_TICK, 1'b0, 1'b0, '0));

    // random phases over a range of gain settings
    recentre_drive();
    wait_drained(SETTLE);
    pid_gains();
    run_phase(PHASE_ITEMS);

    recentre_drive();
    wait_drained(SETTLE);
    write_gains($urandom_range(0, 1 << 19) - (1 << 18),
                $urandom_range(0, 1 << 19) - (1 << 18),
                $urandom_range(0, 1 << 19) - (1 << 18));
    run_phase(PHASE_ITEMS);

    recentre_drive();
    wait_drained(SETTLE);
    pid_gains();
    quiet = 1'b1;
    run_phase(PHASE_ITEMS);
    quiet = 1'b0;

    wait_drained(SETTLE);
    write_gains($urandom, $urandom, $urandom);
    run_phase(PHASE_ITEMS);

    wait_drained(SETTLE);
    write_gains(extreme_gain(), extreme_gain(), extreme_gain());
    run_phase(PHASE_ITEMS);

    wait_drained(2 * SETTLE);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qpps_pkg.sv
rtl/qpps_servo_path.sv
rtl/quadrature_position_pid_servo_unit.sv
tb/quadrature_position_pid_servo_unit_test.sv
